@@ rtl/ukfq_pkg.sv @@
// Shared types and constants for the unique-key FIFO queue.
// No dependencies; used by every other file of the block.
package ukfq_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH,
        S_LOAD,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } entry_t;

endpackage

@@ rtl/ukfq_if.sv @@
// Valid/ready channel interfaces for the request and response words.
// Depends on ukfq_pkg.
interface ukfq_req_if;
    logic                                  valid;
    logic                                  ready;
    ukfq_pkg::opcode_t                     opcode;
    logic signed [ukfq_pkg::KEY_W-1:0]     key_in;
    logic signed [ukfq_pkg::VAL_W-1:0]     value_in;
    logic        [ukfq_pkg::POS_W-1:0]     position;

    modport source (output valid, opcode, key_in, value_in, position, input ready);
    modport sink   (input valid, opcode, key_in, value_in, position, output ready);
endinterface

interface ukfq_rsp_if #(
    parameter int CNT_W = 5
);
    logic                                  valid;
    logic                                  ready;
    ukfq_pkg::status_t                     status;
    logic signed [ukfq_pkg::KEY_W-1:0]     key_out;
    logic signed [ukfq_pkg::VAL_W-1:0]     value_out;
    logic        [CNT_W-1:0]               count;

    modport source (output valid, status, key_out, value_out, count, input ready);
    modport sink   (input valid, status, key_out, value_out, count, output ready);
endinterface

@@ rtl/ukfq_mem.sv @@
// Key/value entry storage: one write port, one read port with registered data.
// Depends on ukfq_pkg.
module ukfq_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  ukfq_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output ukfq_pkg::entry_t  rd_data
);

    ukfq_pkg::entry_t mem [DEPTH];
    ukfq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ukfq_ctrl.sv @@
// Sequencer, slot adder, key comparator and queue pointers; owns the response register.
// Depends on ukfq_pkg, ukfq_if; drives the ports of ukfq_mem.
module ukfq_ctrl #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    ukfq_req_if.sink          req,
    ukfq_rsp_if.source        rsp,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output ukfq_pkg::entry_t  wr_data,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_addr,
    input  ukfq_pkg::entry_t  rd_data
);

    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > ukfq_pkg::POS_W) ? CNT_W : ukfq_pkg::POS_W;

    ukfq_pkg::state_t   state_reg, state_next;
    ukfq_pkg::opcode_t  op_reg;
    ukfq_pkg::status_t  status_reg;
    logic signed [ukfq_pkg::KEY_W-1:0] key_reg, kout_reg;
    logic signed [ukfq_pkg::VAL_W-1:0] val_reg, vout_reg;
    logic [IDX_W-1:0]   off_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               pend_reg;

    logic               out_valid_reg;
    ukfq_pkg::status_t  out_status_reg;
    logic signed [ukfq_pkg::KEY_W-1:0] out_key_reg;
    logic signed [ukfq_pkg::VAL_W-1:0] out_val_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic               accept;
    logic               out_free;
    logic               issue;
    logic               match;
    logic               search_done;
    logic               finish_fire;
    logic               pos_ok;
    logic [CNT_W-1:0]   offset;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   wrapped;
    logic [IDX_W-1:0]   slot;
    logic               commit_ok;

    // shared slot adder: (head + offset) mod DEPTH, offset below 2*DEPTH - head
    assign sum     = SUM_W'(head_reg) + SUM_W'(offset);
    assign wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
    assign slot    = wrapped[IDX_W-1:0];

    assign pos_ok  = CMP_W'(req.position) < CMP_W'(count_reg);
    assign match   = pend_reg && (rd_data.key == key_reg);
    assign out_free = !out_valid_reg || rsp.ready;
    assign accept  = req.valid && req.ready;
    assign commit_ok = status_reg == ukfq_pkg::ST_OK;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ukfq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.opcode)
                        ukfq_pkg::OP_INSERT:
                            state_next = (count_reg == '0) ? ukfq_pkg::S_FINISH
                                                           : ukfq_pkg::S_SEARCH;
                        ukfq_pkg::OP_POP:
                            state_next = (count_reg != '0) ? ukfq_pkg::S_FETCH
                                                           : ukfq_pkg::S_FINISH;
                        ukfq_pkg::OP_READ:
                            state_next = pos_ok ? ukfq_pkg::S_FETCH : ukfq_pkg::S_FINISH;
                        default:
                            state_next = ukfq_pkg::S_FINISH;
                    endcase
                end
            end
            ukfq_pkg::S_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = ukfq_pkg::S_FINISH;
                end
            end
            ukfq_pkg::S_FETCH:
                state_next = ukfq_pkg::S_LOAD;
            ukfq_pkg::S_LOAD:
                state_next = ukfq_pkg::S_FINISH;
            ukfq_pkg::S_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = ukfq_pkg::S_IDLE;
                end
            end
            default:
                state_next = ukfq_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready   = 1'b0;
        issue       = 1'b0;
        search_done = 1'b0;
        finish_fire = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        offset      = '0;
        unique case (state_reg)
            ukfq_pkg::S_IDLE:
                req.ready = 1'b1;
            ukfq_pkg::S_SEARCH:
            begin
                issue       = idx_reg < count_reg;
                search_done = match || !issue;
                rd_en       = issue;
                offset      = idx_reg;
            end
            ukfq_pkg::S_FETCH:
            begin
                rd_en  = 1'b1;
                offset = (op_reg == ukfq_pkg::OP_POP) ? '0 : CNT_W'(off_reg);
            end
            ukfq_pkg::S_LOAD:
                offset = '0;
            ukfq_pkg::S_FINISH:
            begin
                finish_fire = out_free;
                wr_en  = out_free && commit_ok && (op_reg == ukfq_pkg::OP_INSERT);
                offset = (op_reg == ukfq_pkg::OP_INSERT) ? count_reg : CNT_W'(1);
            end
            default:
                offset = '0;
        endcase
    end

    assign rd_addr = slot;
    assign wr_addr = slot;
    assign wr_data = '{key: key_reg, value: val_reg};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ukfq_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (state_reg == ukfq_pkg::S_SEARCH)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            if (finish_fire && commit_ok)
            begin
                if (op_reg == ukfq_pkg::OP_INSERT)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (op_reg == ukfq_pkg::OP_POP)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                    head_reg  <= slot;
                end
            end
            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.opcode;
            key_reg  <= req.key_in;
            val_reg  <= req.value_in;
            off_reg  <= req.position[IDX_W-1:0];
            kout_reg <= '0;
            vout_reg <= '0;
            status_reg <= ((req.opcode == ukfq_pkg::OP_INSERT) && (count_reg == '0))
                          ? ukfq_pkg::ST_OK : ukfq_pkg::ST_EMPTY;
        end
        else if (search_done)
        begin
            if (match)
            begin
                status_reg <= ukfq_pkg::ST_DUP;
            end
            else if (count_reg == CNT_W'(DEPTH))
            begin
                status_reg <= ukfq_pkg::ST_FULL;
            end
            else
            begin
                status_reg <= ukfq_pkg::ST_OK;
            end
        end
        else if (state_reg == ukfq_pkg::S_LOAD)
        begin
            kout_reg   <= rd_data.key;
            vout_reg   <= rd_data.value;
            status_reg <= ukfq_pkg::ST_OK;
        end
        if (finish_fire)
        begin
            out_status_reg <= status_reg;
            out_key_reg    <= kout_reg;
            out_val_reg    <= vout_reg;
            if (!commit_ok || op_reg == ukfq_pkg::OP_READ || op_reg == ukfq_pkg::OP_NONE)
            begin
                out_count_reg <= count_reg;
            end
            else if (op_reg == ukfq_pkg::OP_INSERT)
            begin
                out_count_reg <= count_reg + CNT_W'(1);
            end
            else
            begin
                out_count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.key_out   = out_key_reg;
    assign rsp.value_out = out_val_reg;
    assign rsp.count     = out_count_reg;

endmodule

@@ rtl/unique_key_fifo_queue_top.sv @@
// FIFO queue of key/value pairs with duplicate-key rejection: top level.
// Depends on ukfq_pkg, ukfq_if, ukfq_mem, ukfq_ctrl.
//
// A request word carries an opcode (insert, pop, read at position); every request gives
// exactly one response word with status, key, value and the entry count after the
// operation. The queue is a ring of DEPTH entries in a single-port-read memory, so an
// insert walks the stored keys one per cycle until a duplicate key turns up or all are
// compared, and skips the walk on an empty queue, while pop and read pass through a fetch
// and a load state (skipped when the queue is empty, the position is out of range or the
// opcode is unused). The block takes one request at a time; a finished response sits in
// an output register, so the next request is accepted while it waits, and that request
// holds in its last cycle until the register is free.
// No clearing pass follows reset; storage is only read below the count.
module unique_key_fifo_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ukfq_req_if.sink   req,
    ukfq_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    ukfq_pkg::entry_t  wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    ukfq_pkg::entry_t  rd_data;

    ukfq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ukfq_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

@@ rtl/ukfq_checker.sv @@
// Port-level assertions for the unique-key FIFO queue, bound to the top level.
// Depends on ukfq_pkg and unique_key_fifo_queue_top.
module ukfq_checker #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  ukfq_pkg::status_t                  rsp_status,
    input  logic signed [ukfq_pkg::KEY_W-1:0]  rsp_key,
    input  logic signed [ukfq_pkg::VAL_W-1:0]  rsp_value,
    input  logic [CNT_W-1:0]                   rsp_count
);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ukfq_pkg::ST_OK |-> rsp_key == '0 && rsp_value == '0)
        else $error("nonzero data on failed operation");

    a_dup_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ukfq_pkg::ST_DUP |-> rsp_count != '0)
        else $error("duplicate reported on empty queue");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken on consecutive cycles");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status))
        else $error("stalled response changed");

endmodule

bind unique_key_fifo_queue_top ukfq_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_ukfq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_key    (rsp.key_out),
    .rsp_value  (rsp.value_out),
    .rsp_count  (rsp.count)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for unique_key_fifo_queue_top: a directed table and then random traffic,
// checked word by word against the table's expected words or a shadow copy of the queue under varying idling.
// Depends on ukfq_pkg, ukfq_if and the block's RTL.
module tb;
    import ukfq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int CNT_W          = 5;
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PER_PHASE = 280;
    localparam int PRESSURE_ITEMS = 30;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_CYCLES     = 1000000;
    localparam int MAX_REPORTS    = 200;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        status_t          st;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] cnt;
    } reply_t;

    typedef struct {
        opcode_t          op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        bit               typed;
        reply_t           want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    ukfq_req_if                  req_ch ();
    ukfq_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

    unique_key_fifo_queue_top #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [KEY_W-1:0] shadow_keys [DEPTH];
    logic [VAL_W-1:0] shadow_vals [DEPTH];
    logic [3:0]       shadow_head;
    logic [CNT_W-1:0] shadow_count;
    reply_t           queue_replies [$];
    plan_row_t        plan [$];
    idle_mode_t       idle_mode = IDLE_NONE;
    bit               hold_req  = 1'b0;
    int               fails     = 0;
    int               cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic reply_t apply_queue_op(opcode_t op, logic [KEY_W-1:0] key,
                                              logic [VAL_W-1:0] val, logic [POS_W-1:0] pos);
        reply_t     r;
        bit         seen;
        logic [3:0] slot;
        r    = '0;
        r.st = ST_EMPTY;
        seen = 1'b0;
        case (op)
            OP_INSERT:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    slot = shadow_head + 4'(i);
                    if (shadow_keys[slot] == key)
                        seen = 1'b1;
                end
                if (seen)
                    r.st = ST_DUP;
                else if (shadow_count == CNT_W'(DEPTH))
                    r.st = ST_FULL;
                else
                begin
                    slot              = shadow_head + shadow_count[3:0];
                    shadow_keys[slot] = key;
                    shadow_vals[slot] = val;
                    shadow_count      = shadow_count + 1'b1;
                    r.st              = ST_OK;
                end
            end
            OP_POP:
            begin
                if (shadow_count != '0)
                begin
                    r.key        = shadow_keys[shadow_head];
                    r.val        = shadow_vals[shadow_head];
                    shadow_head  = shadow_head + 4'd1;
                    shadow_count = shadow_count - 1'b1;
                    r.st         = ST_OK;
                end
            end
            OP_READ:
            begin
                if (pos < POS_W'(shadow_count))
                begin
                    slot  = shadow_head + pos[3:0];
                    r.key = shadow_keys[slot];
                    r.val = shadow_vals[slot];
                    r.st  = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = shadow_count;
        return r;
    endfunction

    function automatic int sender_gap();
        int g;
        int pct;
        g   = 0;
        pct = (idle_mode == IDLE_SEND) ? 80 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        while (g < 60 && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    task automatic send_word(opcode_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                             logic [POS_W-1:0] pos, bit typed, reply_t want);
        int     gap;
        reply_t r;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.key_in   <= key;
        req_ch.value_in <= val;
        req_ch.position <= pos;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        r = apply_queue_op(op, key, val, pos);
        queue_replies.push_back(typed ? want : r);
    endtask

    function automatic void add_row(opcode_t op, logic [KEY_W-1:0] key,
                                    logic [VAL_W-1:0] val, logic [POS_W-1:0] pos, bit typed,
                                    status_t st, logic [KEY_W-1:0] k_exp,
                                    logic [VAL_W-1:0] v_exp, int c_exp);
        plan_row_t row;
        row.op       = op;
        row.key      = key;
        row.val      = val;
        row.pos      = pos;
        row.typed    = typed;
        row.want.st  = st;
        row.want.key = k_exp;
        row.want.val = v_exp;
        row.want.cnt = CNT_W'(c_exp);
        plan.push_back(row);
    endfunction

    task automatic random_items(int n);
        int               burst_left;
        bit               filling;
        int               roll;
        opcode_t          op;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        burst_left = 0;
        filling    = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            // bursts that lean toward filling or draining, so full and empty both recur
            if (burst_left == 0)
            begin
                filling    = $urandom_range(1);
                burst_left = $urandom_range(4, 30);
            end
            burst_left--;
            roll = $urandom_range(99);
            if (roll < 5)
                op = OP_NONE;
            else if (roll < 25)
                op = OP_READ;
            else if (roll < (filling ? 85 : 50))
                op = OP_INSERT;
            else
                op = OP_POP;
            roll = $urandom_range(99);
            if (roll < 60)
                key = KEY_W'($urandom_range(23));
            else if (roll < 70)
                key = {1'b1, 26'd0, 5'($urandom_range(31))};
            else
                key = $urandom;
            if ($urandom_range(3) == 0)
                pos = POS_W'($urandom);
            else
                pos = POS_W'($urandom_range(shadow_count));
            send_word(op, key, $urandom, pos, 1'b0, '0);
        end
    endtask

    // response side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_count;
        int pct;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
            end
            pct = (idle_mode == IDLE_RECV) ? 80 : (idle_mode == IDLE_BOTH) ? 6 : 0;
            rsp_ch.ready <= ($urandom_range(99) >= pct);
        end
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (queue_replies.size() == 0)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("%0t: expected nothing, got status=%0d key=%h value=%h count=%0d",
                             $time, rsp_ch.status, rsp_ch.key_out, rsp_ch.value_out,
                             rsp_ch.count);
            end
            else
            begin
                want = queue_replies.pop_front();
                if (rsp_ch.status !== want.st || rsp_ch.key_out !== want.key ||
                    rsp_ch.value_out !== want.val || rsp_ch.count !== want.cnt)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: expected status=%0d key=%h value=%h count=%0d, %s%0d%s",
                                 $time, want.st, want.key, want.val, want.cnt,
                                 "got status=", rsp_ch.status,
                                 $sformatf(" key=%h value=%h count=%0d", rsp_ch.key_out,
                                           rsp_ch.value_out, rsp_ch.count));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.opcode   <= OP_NONE;
        req_ch.key_in   <= '0;
        req_ch.value_in <= '0;
        req_ch.position <= '0;
        shadow_head      = '0;
        shadow_count     = '0;

        add_row(OP_POP,    32'h0,        32'h0,        8'd0,   1, ST_EMPTY, 0, 0, 0);
        add_row(OP_READ,   32'h0,        32'h0,        8'd0,   1, ST_EMPTY, 0, 0, 0);
        add_row(OP_NONE,   32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,  1, ST_EMPTY, 0, 0, 0);
        add_row(OP_INSERT, 32'h80000000, 32'h7FFFFFFF, 8'd0,   1, ST_OK,    0, 0, 1);
        add_row(OP_INSERT, 32'h7FFFFFFF, 32'h80000000, 8'd0,   1, ST_OK,    0, 0, 2);
        add_row(OP_INSERT, 32'h80000000, 32'h0,        8'd0,   1, ST_DUP,   0, 0, 2);
        add_row(OP_READ,   32'h0,        32'h0,        8'hFF,  1, ST_EMPTY, 0, 0, 2);
        add_row(OP_READ,   32'h0,        32'h0,        8'd2,   1, ST_EMPTY, 0, 0, 2);
        add_row(OP_READ,   32'h0,        32'h0,        8'd1,   1, ST_OK,
                32'h7FFFFFFF, 32'h80000000, 2);
        add_row(OP_POP,    32'h0,        32'h0,        8'd0,   1, ST_OK,
                32'h80000000, 32'h7FFFFFFF, 1);
        for (int k = 2; k <= DEPTH; k++)
            add_row(OP_INSERT, KEY_W'(k), ~VAL_W'(k), 8'd0, 1, ST_OK, 0, 0, k);
        add_row(OP_INSERT, 32'hDEADBEEF, 32'h1,        8'd0,   1, ST_FULL,  0, 0, DEPTH);
        add_row(OP_INSERT, 32'd9,        32'h2,        8'd0,   1, ST_DUP,   0, 0, DEPTH);
        add_row(OP_READ,   32'h0,        32'h0,        8'd15,  1, ST_OK,
                32'd16, ~32'd16, DEPTH);
        add_row(OP_READ,   32'h0,        32'h0,        8'd7,   0, ST_OK,    0, 0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(plan[i].op, plan[i].key, plan[i].val, plan[i].pos, plan[i].typed,
                      plan[i].want);

        for (int m = 0; m < 4; m++)
        begin
            idle_mode = idle_mode_t'(m);
            random_items(RAND_PER_PHASE);
        end

        // long receiver hold-off while requests keep coming
        idle_mode = IDLE_NONE;
        hold_req  = 1'b1;
        random_items(PRESSURE_ITEMS);

        req_ch.valid <= 1'b0;
        while (queue_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
